FILE: src/frc_pkg.sv
// Shared types, constants and helpers for the framebuffer region copy block.
`default_nettype none
package frc_pkg;

  localparam int MAX_WIDTH  = 320;
  localparam int MAX_HEIGHT = 240;
  localparam int PIXEL_BITS = 4;

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Field widths of the ports
  localparam int KIND_W = 2;
  localparam int X_W    = 9;
  localparam int Y_W    = 8;
  localparam int PIN_W  = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Signed coordinate wide enough for any position plus an 8-bit offset
  localparam int CRD_W = 12;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [PIXEL_BITS-1:0]   pix_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_COPY  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic clr;
    logic plan_a;
    logic plan_b;
    logic rd;
    logic wr;
    logic out_load;
  } frc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic copy_empty;
    logic scan_last;
    kind_t kind;
  } frc_sts_t;

  function automatic pix_t pix_from_in(logic [PIN_W-1:0] v);
    logic [15:0] w;
    w = 16'(v);
    return w[PIXEL_BITS-1:0];
  endfunction

  function automatic logic [PIN_W-1:0] pix_to_out(pix_t p);
    logic [15:0] w;
    w = 16'(p);
    return w[PIN_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/frc_ctrl.sv
// Sequencer for pixel accesses, copy scans and the post-reset clear sweep.
`default_nettype none
module frc_ctrl
  import frc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  frc_sts_t          sts,
  output frc_cmd_t          cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_PLAN_A = 7'b0000100,
    ST_PLAN_B = 7'b0001000,
    ST_RD     = 7'b0010000,
    ST_WR     = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (kind_t'(in_kind))
            KIND_WRITE: state_nxt = ST_WR;
            KIND_READ:  state_nxt = ST_RD;
            KIND_COPY:  state_nxt = ST_PLAN_A;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_PLAN_A: begin
        cmd.plan_a = 1'b1;
        state_nxt  = ST_PLAN_B;
      end
      ST_PLAN_B: begin
        cmd.plan_b = 1'b1;
        state_nxt  = sts.copy_empty ? ST_RESP : ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = (sts.kind == KIND_READ) ? ST_RESP : ST_WR;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (sts.kind == KIND_WRITE || sts.scan_last) state_nxt = ST_RESP;
        else state_nxt = ST_RD;
      end
      ST_RESP: begin
        // wait for the output slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: src/frc_datapath.sv
// Pixel memory, screen registers, copy scan planning and coordinate counters.
`default_nettype none
module frc_datapath
  import frc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [X_W-1:0]        in_x_first,
  input  logic [Y_W-1:0]        in_y_first,
  input  logic [X_W-1:0]        in_x_last,
  input  logic [Y_W-1:0]        in_y_last,
  input  logic [X_W-1:0]        in_dest_x,
  input  logic [Y_W-1:0]        in_dest_y,
  input  logic [PIN_W-1:0]      in_pixel_in,
  input  frc_cmd_t              cmd,
  output frc_sts_t              sts,
  output logic [PIN_W-1:0]      out_pixel_out,
  output logic [KIND_W-1:0]     out_done_kind
);

  function automatic crd_t off8(crd_t first, crd_t dest);
    logic [7:0] d;
    d = 8'(dest - first);
    return crd_t'($signed(d));
  endfunction

  function automatic logic on_scr(crd_t x, crd_t y, crd_t w, crd_t h);
    return !x[CRD_W-1] && !y[CRD_W-1] && (x < w) && (y < h);
  endfunction

  function automatic addr_t pix_addr(crd_t x, crd_t y);
    addr_t xa, ya;
    xa = addr_t'($unsigned(x));
    ya = addr_t'($unsigned(y));
    return addr_t'(ya * addr_t'(MAX_WIDTH) + xa);
  endfunction

  // Screen registers and clear counter
  logic [X_W-1:0] scr_w_r;
  logic [Y_W-1:0] scr_h_r;
  addr_t          clr_cnt_r;

  // Item fields
  kind_t kind_r;
  crd_t  x_first_r, y_first_r, x_last_r, y_last_r, dest_x_r, dest_y_r;
  pix_t  pix_in_r;

  // Scan plan
  crd_t xo_r, yo_r, xlm_r, ylm_r;
  logic xfwd_r, yfwd_r, xclip_r, yclip_r;
  crd_t xs_r, xe_r, ye_r;

  // Scan position
  crd_t cx_r, cy_r, dx_r, dy_r;
  logic src_ok_r;
  pix_t rd_data_r;

  logic [PIN_W-1:0]  pout_r;
  logic [KIND_W-1:0] dkind_r;

  pix_t pix_mem_r [MEM_DEPTH];

  crd_t  eff_w, eff_h;
  crd_t  xo_c, yo_c;
  crd_t  xs_c, xe_c, ys_c, ye_c;
  logic  xempty_c, yempty_c;
  logic  src_ok, dst_ok;
  addr_t src_addr, dst_addr;
  logic  mem_we, mem_re;
  addr_t mem_waddr;
  pix_t  mem_wdata, copy_data;

  assign eff_w = (crd_t'(scr_w_r) > crd_t'(MAX_WIDTH)) ? crd_t'(MAX_WIDTH) : crd_t'(scr_w_r);
  assign eff_h = (crd_t'(scr_h_r) > crd_t'(MAX_HEIGHT)) ? crd_t'(MAX_HEIGHT) : crd_t'(scr_h_r);

  assign xo_c = off8(x_first_r, dest_x_r);
  assign yo_c = off8(y_first_r, dest_y_r);

  // Forward scans run first to last; backward scans start at a clipped last
  assign xs_c     = xfwd_r ? x_first_r : (xclip_r ? xlm_r : x_last_r);
  assign xe_c     = xfwd_r ? x_last_r : x_first_r;
  assign xempty_c = xfwd_r ? (x_last_r < x_first_r) : (xs_c < x_first_r);
  assign ys_c     = yfwd_r ? y_first_r : (yclip_r ? ylm_r : y_last_r);
  assign ye_c     = yfwd_r ? y_last_r : y_first_r;
  assign yempty_c = yfwd_r ? (y_last_r < y_first_r) : (ys_c < y_first_r);

  assign src_ok   = on_scr(cx_r, cy_r, eff_w, eff_h);
  assign src_addr = pix_addr(cx_r, cy_r);
  assign dst_ok   = on_scr(dx_r, dy_r, eff_w, eff_h);
  assign dst_addr = pix_addr(dx_r, dy_r);

  assign copy_data = src_ok_r ? rd_data_r : '0;

  assign mem_re    = cmd.rd && src_ok;
  assign mem_we    = cmd.clr || (cmd.wr && dst_ok);
  assign mem_waddr = cmd.clr ? clr_cnt_r : dst_addr;
  assign mem_wdata = cmd.clr ? '0 : ((kind_r == KIND_WRITE) ? pix_in_r : copy_data);

  always_ff @(posedge clk) begin
    if (mem_we) pix_mem_r[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= pix_mem_r[src_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r   <= X_W'(320);
      scr_h_r   <= Y_W'(240);
      clr_cnt_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data[X_W-1:0];
          CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data[Y_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + addr_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= kind_t'(in_kind);
      x_first_r <= crd_t'(in_x_first);
      y_first_r <= crd_t'(in_y_first);
      x_last_r  <= crd_t'(in_x_last);
      y_last_r  <= crd_t'(in_y_last);
      dest_x_r  <= crd_t'(in_dest_x);
      dest_y_r  <= crd_t'(in_dest_y);
      pix_in_r  <= pix_from_in(in_pixel_in);
      cx_r      <= crd_t'(in_x_first);
      cy_r      <= crd_t'(in_y_first);
      dx_r      <= crd_t'(in_x_first);
      dy_r      <= crd_t'(in_y_first);
    end
    if (cmd.plan_a) begin
      xo_r    <= xo_c;
      yo_r    <= yo_c;
      xfwd_r  <= x_first_r > dest_x_r;
      yfwd_r  <= y_first_r > dest_y_r;
      xclip_r <= (x_last_r + xo_c) >= eff_w;
      yclip_r <= (y_last_r + yo_c) >= eff_h;
      xlm_r   <= eff_w - xo_c - crd_t'(1);
      ylm_r   <= eff_h - yo_c - crd_t'(1);
    end
    if (cmd.plan_b) begin
      xs_r <= xs_c;
      xe_r <= xe_c;
      ye_r <= ye_c;
      cx_r <= xs_c;
      cy_r <= ys_c;
    end
    if (cmd.rd) begin
      src_ok_r <= src_ok;
      dx_r     <= cx_r + xo_r;
      dy_r     <= cy_r + yo_r;
    end
    if (cmd.wr && kind_r == KIND_COPY) begin
      // step along the row, then to the next row
      if (cx_r == xe_r) begin
        cx_r <= xs_r;
        cy_r <= yfwd_r ? cy_r + crd_t'(1) : cy_r - crd_t'(1);
      end else begin
        cx_r <= xfwd_r ? cx_r + crd_t'(1) : cx_r - crd_t'(1);
      end
    end
    if (cmd.out_load) begin
      pout_r  <= (kind_r == KIND_READ && src_ok_r) ? pix_to_out(rd_data_r) : '0;
      dkind_r <= kind_r;
    end
  end

  assign sts.clr_last   = (clr_cnt_r == addr_t'(MEM_DEPTH - 1));
  assign sts.copy_empty = xempty_c || yempty_c;
  assign sts.scan_last  = (cx_r == xe_r) && (cy_r == ye_r);
  assign sts.kind       = kind_r;

  assign out_pixel_out = pout_r;
  assign out_done_kind = dkind_r;

endmodule
`default_nettype wire

FILE: src/framebuffer_region_copy.sv
// Top level of the framebuffer region copy block.
// Holds a 320x240 store of 4-bit pixels and handles one item at a time: a
// pixel write passes through a write state and a pixel read through a read
// state before the response state, and a rectangle copy plans its scan and
// then reads and writes each moved pixel in turn. Each item returns
// one result through an output register that frees the input as soon as the
// result is loaded, so the next item is accepted while a result waits. After
// reset the store is swept to zero, one pixel a cycle; no item is accepted
// until that ends, configuration writes are taken at any time.
`default_nettype none
module framebuffer_region_copy
  import frc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [X_W-1:0]        in_x_first,
  input  logic [Y_W-1:0]        in_y_first,
  input  logic [X_W-1:0]        in_x_last,
  input  logic [Y_W-1:0]        in_y_last,
  input  logic [X_W-1:0]        in_dest_x,
  input  logic [Y_W-1:0]        in_dest_y,
  input  logic [PIN_W-1:0]      in_pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIN_W-1:0]      out_pixel_out,
  output logic [KIND_W-1:0]     out_done_kind
);

  frc_cmd_t cmd;
  frc_sts_t sts;

  assign cfg_ready = 1'b1;

  frc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  frc_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_kind),
    .in_x_first    (in_x_first),
    .in_y_first    (in_y_first),
    .in_x_last     (in_x_last),
    .in_y_last     (in_y_last),
    .in_dest_x     (in_dest_x),
    .in_dest_y     (in_dest_y),
    .in_pixel_in   (in_pixel_in),
    .cmd           (cmd),
    .sts           (sts),
    .out_pixel_out (out_pixel_out),
    .out_done_kind (out_done_kind)
  );

endmodule
`default_nettype wire

FILE: src/frc_checker.sv
// Port-level checks for the framebuffer region copy block, bound to its top.
`default_nettype none
module frc_checker
  import frc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PIN_W-1:0]      out_pixel_out,
  input logic [KIND_W-1:0]     out_done_kind
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) && $stable(out_done_kind))
    else $error("result changed while stalled");

  // Only reads return pixel data
  a_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_done_kind != KIND_READ) |-> out_pixel_out == '0)
    else $error("nonzero pixel on a non-read result");

  // One item in flight: acceptance closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  // The clear sweep keeps the input closed right after reset
  a_clear_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("input open or result shown during clear");

endmodule

bind framebuffer_region_copy frc_checker u_frc_checker (.*);
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for framebuffer_region_copy: pixel writes, reads and rectangle copies.
module tb_top;
  import frc_pkg::*;

  localparam int STUCK_LIMIT = 600000;

  typedef struct {
    kind_t            kind;
    logic [X_W-1:0]   xf;
    logic [Y_W-1:0]   yf;
    logic [X_W-1:0]   xl;
    logic [Y_W-1:0]   yl;
    logic [X_W-1:0]   dx;
    logic [Y_W-1:0]   dy;
    logic [PIN_W-1:0] pix;
  } fb_op_t;

  typedef struct {
    logic [PIN_W-1:0] pix;
    kind_t            kind;
  } fb_res_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [X_W-1:0]        in_x_first = '0;
  logic [Y_W-1:0]        in_y_first = '0;
  logic [X_W-1:0]        in_x_last = '0;
  logic [Y_W-1:0]        in_y_last = '0;
  logic [X_W-1:0]        in_dest_x = '0;
  logic [Y_W-1:0]        in_dest_y = '0;
  logic [PIN_W-1:0]      in_pixel_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIN_W-1:0]      out_pixel_out;
  logic [KIND_W-1:0]     out_done_kind;

  // shadow of the pixel store and the screen registers
  pix_t            shadow_fb [MEM_DEPTH];
  logic [X_W-1:0]  scr_w;
  logic [Y_W-1:0]  scr_h;

  fb_op_t  op_q[$];
  fb_res_t result_q[$];

  int n_bad = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  framebuffer_region_copy u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_x_first    (in_x_first),
    .in_y_first    (in_y_first),
    .in_x_last     (in_x_last),
    .in_y_last     (in_y_last),
    .in_dest_x     (in_dest_x),
    .in_dest_y     (in_dest_y),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_done_kind (out_done_kind)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int eff_w();
    return (int'(scr_w) > MAX_WIDTH) ? MAX_WIDTH : int'(scr_w);
  endfunction

  function automatic int eff_h();
    return (int'(scr_h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(scr_h);
  endfunction

  function automatic bit on_screen(int x, int y);
    return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
  endfunction

  function automatic pix_t shadow_rd(int x, int y);
    if (!on_screen(x, y)) return '0;
    return shadow_fb[y * MAX_WIDTH + x];
  endfunction

  function automatic void shadow_wr(int x, int y, pix_t v);
    if (on_screen(x, y)) shadow_fb[y * MAX_WIDTH + x] = v;
  endfunction

  // One axis of a copy: scan direction away from the overlap, start clipped
  // so a forward move stays on screen. Returns 0 when the axis is empty.
  function automatic bit scan_bounds(input int first, input int last, input int dest,
                                     input int lim, output int start, output int stop,
                                     output int stride, output int off);
    off = (dest - first) & 255;
    if (off >= 128) off -= 256;
    if (first > dest) begin
      start = first;
      stop = last;
      stride = 1;
      return last >= first;
    end
    start = last;
    if (last + off >= lim) start = lim - off - 1;
    stop = first;
    stride = -1;
    return start >= first;
  endfunction

  function automatic void shadow_move(fb_op_t op);
    int xs, xe, xd, xo, ys, ye, yd, yo, nx, ny, x, y;
    if (!scan_bounds(int'(op.xf), int'(op.xl), int'(op.dx), eff_w(), xs, xe, xd, xo)) return;
    if (!scan_bounds(int'(op.yf), int'(op.yl), int'(op.dy), eff_h(), ys, ye, yd, yo)) return;
    nx = (xe - xs) * xd + 1;
    ny = (ye - ys) * yd + 1;
    for (int j = 0; j < ny; j++) begin
      y = ys + j * yd;
      for (int i = 0; i < nx; i++) begin
        x = xs + i * xd;
        shadow_wr(x + xo, y + yo, shadow_rd(x, y));
      end
    end
  endfunction

  function automatic void predict_op(fb_op_t op);
    fb_res_t r;
    r.kind = op.kind;
    r.pix = '0;
    case (op.kind)
      KIND_WRITE: shadow_wr(int'(op.xf), int'(op.yf), pix_t'(op.pix));
      KIND_READ:  r.pix = PIN_W'(shadow_rd(int'(op.xf), int'(op.yf)));
      KIND_COPY:  shadow_move(op);
      default: ;
    endcase
    result_q.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Often a small hot window so reads see earlier writes; some edge and
  // out-of-range values.
  function automatic int pick_coord(int eff, int range_hi, int full_hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 15);
    if (r < 70) return $urandom_range(0, (eff > 0) ? eff - 1 : 0);
    if (r < 85) return $urandom_range(0, range_hi);
    if (r < 95) return $urandom_range((eff > 2) ? eff - 2 : 0, eff + 1);
    return $urandom_range(0, full_hi);
  endfunction

  function automatic int span_end(int first);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return first - int'($urandom_range(1, 4));
    if (r < 11) return first + int'($urandom_range(8, 40));
    return first + int'($urandom_range(0, 7));
  endfunction

  function automatic int near_dest(int first, int eff, int range_hi, int full_hi);
    if ($urandom_range(0, 99) < 70) return first + int'($urandom_range(0, 10)) - 5;
    return pick_coord(eff, range_hi, full_hi);
  endfunction

  function automatic fb_op_t random_op();
    fb_op_t op;
    int r, xf, yf;
    r = $urandom_range(0, 99);
    op.kind = (r < 38) ? KIND_WRITE : (r < 72) ? KIND_READ : (r < 97) ? KIND_COPY : KIND_NONE;
    xf = pick_coord(eff_w(), MAX_WIDTH - 1, 511);
    yf = pick_coord(eff_h(), MAX_HEIGHT - 1, 255);
    op.xf = X_W'(xf);
    op.yf = Y_W'(yf);
    op.pix = PIN_W'($urandom_range(0, 15));
    if (op.kind == KIND_COPY) begin
      op.xl = X_W'(span_end(xf));
      op.yl = Y_W'(span_end(yf));
      op.dx = X_W'(near_dest(xf, eff_w(), MAX_WIDTH - 1, 511));
      op.dy = Y_W'(near_dest(yf, eff_h(), MAX_HEIGHT - 1, 255));
    end else begin
      // ignored by the block, kept noisy
      op.xl = X_W'($urandom);
      op.yl = Y_W'($urandom);
      op.dx = X_W'($urandom);
      op.dy = Y_W'($urandom);
    end
    return op;
  endfunction

  task automatic queue_op(kind_t k, int xf, int yf, int xl, int yl, int dx, int dy, int pix);
    fb_op_t op;
    op.kind = k;
    op.xf = X_W'(xf);
    op.yf = Y_W'(yf);
    op.xl = X_W'(xl);
    op.yl = Y_W'(yl);
    op.dx = X_W'(dx);
    op.dy = Y_W'(dy);
    op.pix = PIN_W'(pix);
    op_q.push_back(op);
  endtask

  task automatic queue_random(int n);
    @(negedge clk);
    repeat (n) op_q.push_back(random_op());
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (op_q.size() != 0 || result_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_screen_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val[Y_W-1:0];
  endtask

  task automatic set_screen(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    wait_quiet();
    repeat (4) @(posedge clk);
    write_screen_reg(CFG_SCREEN_WIDTH, w);
    write_screen_reg(CFG_SCREEN_HEIGHT, h);
  endtask

  // Item driver
  always @(posedge clk) begin
    bit take, keep;
    fb_op_t got;
    take = in_valid && in_ready;
    keep = in_valid && !take;
    if (take) begin
      got = op_q.pop_front();
      predict_op(got);
    end
    if (rst_n && !keep) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (op_q.size() != 0) begin
        keep = 1'b1;
        in_kind <= op_q[0].kind;
        in_x_first <= op_q[0].xf;
        in_y_first <= op_q[0].yf;
        in_x_last <= op_q[0].xl;
        in_y_last <= op_q[0].yl;
        in_dest_x <= op_q[0].dx;
        in_dest_y <= op_q[0].dy;
        in_pixel_in <= op_q[0].pix;
        in_gap = no_idle ? 0 : pick_gap();
      end
    end
    in_valid <= keep;
  end

  // Result monitor
  always @(posedge clk) begin
    bit rdy;
    fb_res_t want;
    if (out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: pixel %0d kind %0d", out_pixel_out, out_done_kind);
      end else begin
        want = result_q.pop_front();
        if (out_pixel_out !== want.pix || out_done_kind !== want.kind) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: expected pixel %0d kind %0d, got pixel %0d kind %0d",
                     want.pix, want.kind, out_pixel_out, out_done_kind);
        end
      end
      out_gap = no_idle ? 0 : pick_gap();
    end
    rdy = 1'b0;
    if (!rst_n) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (out_gap > 0) begin
      out_gap--;
    end else begin
      rdy = 1'b1;
    end
    out_ready <= rdy;
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STUCK_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) shadow_fb[i] = '0;
    scr_w = X_W'(MAX_WIDTH);
    scr_h = Y_W'(MAX_HEIGHT);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    set_screen(9'd320, 9'd240);
    @(negedge clk);
    queue_op(KIND_WRITE, 0, 0, 0, 0, 0, 0, 15);
    queue_op(KIND_WRITE, 319, 239, 0, 0, 0, 0, 10);
    queue_op(KIND_WRITE, 1, 0, 0, 0, 0, 0, 3);
    queue_op(KIND_WRITE, 320, 5, 0, 0, 0, 0, 7);          // just off the right edge
    queue_op(KIND_WRITE, 511, 255, 511, 255, 511, 255, 1);
    queue_op(KIND_READ, 0, 0, 0, 0, 0, 0, 0);
    queue_op(KIND_READ, 319, 239, 0, 0, 0, 0, 0);
    queue_op(KIND_READ, 320, 5, 0, 0, 0, 0, 0);
    queue_op(KIND_NONE, 511, 255, 511, 255, 511, 255, 15);
    queue_op(KIND_COPY, 0, 0, 9, 3, 3, 1, 0);             // overlap, right and down
    queue_op(KIND_COPY, 3, 1, 12, 4, 1, 0, 0);            // overlap, left and up
    queue_op(KIND_COPY, 0, 0, 4, 4, 0, 0, 0);             // no move
    queue_op(KIND_COPY, 300, 200, 319, 239, 310, 220, 0); // clipped at far edges
    queue_op(KIND_COPY, 300, 0, 310, 3, 330, 0, 0);       // clip passes the near edge
    queue_op(KIND_COPY, 300, 0, 305, 3, 10, 0, 0);        // offset wraps, forward scan
    queue_op(KIND_COPY, 0, 0, 5, 2, 200, 0, 0);           // offset wraps, backward scan
    queue_op(KIND_COPY, 9, 2, 3, 1, 20, 20, 0);           // reversed rectangle
    queue_op(KIND_COPY, 316, 0, 325, 2, 0, 10, 0);        // source partly off screen
    queue_op(KIND_COPY, 0, 0, 319, 239, 1, 1, 0);         // whole screen
    queue_op(KIND_READ, 1, 1, 0, 0, 0, 0, 0);
    queue_op(KIND_READ, 319, 239, 0, 0, 0, 0, 0);
    queue_op(KIND_READ, 11, 11, 0, 0, 0, 0, 0);
    queue_op(KIND_COPY, 10, 10, 73, 57, 5, 4, 0);
    queue_op(KIND_READ, 5, 4, 0, 0, 0, 0, 0);
    queue_random(600);

    set_screen(9'd1, 9'd1);
    queue_random(150);

    set_screen(9'd0, 9'd0);
    queue_random(100);

    // values above the store size are clamped; height keeps its low 8 bits
    set_screen(9'd511, 9'h1FF);
    @(negedge clk);
    no_idle = 1'b1;
    queue_random(200);
    wait_quiet();
    no_idle = 1'b0;

    set_screen(CFG_DATA_W'($urandom_range(8, 320)), CFG_DATA_W'($urandom_range(8, 240)));
    queue_random(300);
    hold_left = 600;                                      // output stalled, input backs up

    set_screen(9'd320, 9'd240);
    queue_random(300);

    wait_quiet();
    repeat (20) @(posedge clk);
    if (n_bad == 0 && result_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
